[rtl/range_inversion_counter_unit_assert.svh]
// assertion macros for the range inversion counter unit
// expects i_clk and i_rst_n in the scope of the module that asserts
`ifndef RANGE_INVERSION_COUNTER_UNIT_ASSERT_SVH
`define RANGE_INVERSION_COUNTER_UNIT_ASSERT_SVH

// condition holds at every edge outside reset
`define RIC_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RIC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/ric_pkg.sv]
// shared types and constants of the range inversion counter unit
// no dependencies
package ric_pkg;

    // field and storage widths
    localparam int FIELD_W       = 11;
    localparam int IDX_W         = FIELD_W + 1;
    localparam int CNT_W         = 11;
    localparam int SUM_W         = 12;
    localparam int RUN_W         = 20;
    localparam int OUT_W         = 19;
    localparam int EPOCH_W       = 4;
    localparam int MAX_ELEMS_DEF = 1024;

    localparam logic [FIELD_W-1:0] ELEM_COUNT_RST = 11'd1024;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [FIELD_W-1:0] elem_index;
        logic [FIELD_W-1:0] elem_rank;
        logic [FIELD_W-1:0] query_left;
        logic [FIELD_W-1:0] query_right;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] inversion_count;
        logic             range_error;
    } t_out_item;

    // fenwick entry, valid only when its tag matches the current epoch
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [CNT_W-1:0]   count;
    } t_fw_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PICK,
        ST_RANK,
        ST_ADD,
        ST_SUM,
        ST_APPLY,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        STEP_GROW_L,
        STEP_GROW_R,
        STEP_SHRINK_L,
        STEP_SHRINK_R
    } t_step;

endpackage

[rtl/ric_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// depends on ric_pkg for default sizes
module ric_ram
    import ric_pkg::*;
#(
    parameter int WIDTH = FIELD_W,
    parameter int DEPTH = MAX_ELEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/range_inversion_counter_unit.sv]
// range inversion counter: sliding window over an element store, fenwick tree in ram
// depends on ric_pkg, ric_ram and range_inversion_counter_unit_assert.svh
// query: every window step runs pick, rank, update walk, prefix walk and apply; the walks
// go over the fenwick nodes, both through the single fenwick ram port pair
// load, invalid query: no window walk; every 16th window reset adds a sweep of the whole tree
// sync reset: the same MAX_ELEMS entry sweep runs with stall high, config writes still taken
`include "range_inversion_counter_unit_assert.svh"

module range_inversion_counter_unit
    import ric_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_wr_en,
    input  logic [FIELD_W-1:0] i_cfg_wr_data
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMS - 1);

    // control registers
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [IDX_W-1:0]   r_l, n_l;
    logic [IDX_W-1:0]   r_r, n_r;
    logic [RUN_W-1:0]   r_cnt, n_cnt;
    logic [FIELD_W-1:0] r_elem_count, n_elem_count;
    logic               r_out_valid, n_out_valid;
    logic               r_pend, n_pend;

    // working registers
    t_step              r_step, n_step;
    logic [FIELD_W-1:0] r_v, n_v;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [IDX_W-1:0]   r_ql, n_ql;
    logic [IDX_W-1:0]   r_qr, n_qr;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;

    // memory ports
    logic               st_we, st_re;
    logic [AW-1:0]      st_waddr, st_raddr;
    logic [FIELD_W-1:0] st_rdata;
    logic               fw_we, fw_re;
    logic [AW-1:0]      fw_waddr, fw_raddr;
    t_fw_word           fw_wdata, fw_rdata;

    // helpers
    logic               in_acc, out_acc, load_out, clr_win, err, step_up;
    logic [FIELD_W-1:0] eff_n, v_clamp;
    logic [CNT_W-1:0]   fw_cnt;
    logic [IDX_W-1:0]   lowbit, walk_next, qr_p1, step_pos, width;
    logic               idx_in_n;

    ric_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (i_in_data.elem_rank),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    ric_ram #(
        .WIDTH ($bits(t_fw_word)),
        .DEPTH (MAX_ELEMS)
    ) u_fenwick (
        .i_clk   (i_clk),
        .i_we    (fw_we),
        .i_waddr (fw_waddr),
        .i_wdata (fw_wdata),
        .i_re    (fw_re),
        .i_raddr (fw_raddr),
        .o_rdata (fw_rdata)
    );

    // effective element count clamped into one to the store size
    always_comb begin
        if (r_elem_count == '0) begin
            eff_n = FIELD_W'(1);
        end else if (32'(r_elem_count) > 32'(MAX_ELEMS)) begin
            eff_n = FIELD_W'(MAX_ELEMS);
        end else begin
            eff_n = r_elem_count;
        end
    end

    // handshake
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign out_acc     = r_out_valid && !i_out_stall;
    assign load_out    = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // shared walk unit: lowest set bit, then step up or down the tree
    assign lowbit    = r_idx & (~r_idx + 1'b1);
    assign walk_next = (r_state == ST_ADD) ? r_idx + lowbit : r_idx - lowbit;
    assign idx_in_n  = (r_idx != '0) && (r_idx <= {1'b0, eff_n});

    // stale epoch reads as an empty entry
    assign fw_cnt  = (fw_rdata.tag == r_epoch) ? fw_rdata.count : '0;
    assign step_up = (r_step == STEP_GROW_L) || (r_step == STEP_GROW_R);

    // rank clamp into one to n
    always_comb begin
        if (st_rdata == '0) begin
            v_clamp = FIELD_W'(1);
        end else if (st_rdata > eff_n) begin
            v_clamp = eff_n;
        end else begin
            v_clamp = st_rdata;
        end
    end

    // query range check
    assign qr_p1 = {1'b0, i_in_data.query_right} + 1'b1;
    assign err   = (i_in_data.query_left == '0) || ({1'b0, i_in_data.query_left} > qr_p1) ||
                   (i_in_data.query_right > eff_n);

    // window width term for right end moves
    assign width = (r_step == STEP_GROW_R) ? r_r - r_l + 1'b1 : r_r - r_l;

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_epoch      = r_epoch;
        n_l          = r_l;
        n_r          = r_r;
        n_cnt        = r_cnt;
        n_elem_count = r_elem_count;
        n_pend       = r_pend;
        n_step       = r_step;
        n_v          = r_v;
        n_idx        = r_idx;
        n_pend_idx   = r_pend_idx;
        n_sum        = r_sum;
        n_ql         = r_ql;
        n_qr         = r_qr;
        n_res        = r_res;
        clr_win      = 1'b0;
        step_pos     = '0;
        st_we        = 1'b0;
        st_waddr     = AW'(i_in_data.elem_index - 1'b1);
        st_re        = 1'b0;
        st_raddr     = '0;
        fw_we        = 1'b0;
        fw_waddr     = AW'(r_pend_idx - 1'b1);
        fw_wdata     = '0;
        fw_re        = 1'b0;
        fw_raddr     = AW'(r_idx - 1'b1);

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.operation == OP_LOAD) begin
                        st_we   = (i_in_data.elem_index != '0) &&
                                  (32'(i_in_data.elem_index) <= 32'(MAX_ELEMS));
                        clr_win = 1'b1;
                    end else if (err) begin
                        n_res.inversion_count = '0;
                        n_res.range_error     = 1'b1;
                        n_state               = ST_DONE;
                    end else begin
                        n_ql    = {1'b0, i_in_data.query_left};
                        n_qr    = {1'b0, i_in_data.query_right};
                        n_state = ST_PICK;
                    end
                end
            end
            // tree sweep after reset or epoch wrap
            ST_CLEAR: begin
                fw_we    = 1'b1;
                fw_waddr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_epoch = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            // choose the next window move: grow first, then shrink
            ST_PICK: begin
                n_state = ST_RANK;
                if (r_l > r_ql) begin
                    n_step   = STEP_GROW_L;
                    step_pos = r_l - 1'b1;
                    n_l      = step_pos;
                end else if (r_r < r_qr) begin
                    n_step   = STEP_GROW_R;
                    step_pos = r_r + 1'b1;
                    n_r      = step_pos;
                end else if (r_l < r_ql) begin
                    n_step   = STEP_SHRINK_L;
                    step_pos = r_l;
                end else if (r_r > r_qr) begin
                    n_step   = STEP_SHRINK_R;
                    step_pos = r_r;
                end else begin
                    n_res.inversion_count = r_cnt[OUT_W-1:0];
                    n_res.range_error     = 1'b0;
                    n_state               = ST_DONE;
                end
                st_re    = (n_state == ST_RANK);
                st_raddr = AW'(step_pos - 1'b1);
            end
            ST_RANK: begin
                n_v     = v_clamp;
                n_idx   = {1'b0, v_clamp};
                n_pend  = 1'b0;
                n_sum   = '0;
                n_state = ST_ADD;
            end
            // update walk, read one node while writing back the previous
            ST_ADD: begin
                if (r_pend) begin
                    fw_we          = 1'b1;
                    fw_wdata.tag   = r_epoch;
                    fw_wdata.count = step_up ? fw_cnt + 1'b1 : fw_cnt - 1'b1;
                end
                if (idx_in_n) begin
                    fw_re      = 1'b1;
                    n_idx      = walk_next;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_SUM;
                    if ((r_step == STEP_GROW_L) || (r_step == STEP_SHRINK_L)) begin
                        n_idx = {1'b0, r_v} - 1'b1;
                    end else begin
                        n_idx = {1'b0, r_v};
                    end
                end
            end
            // prefix walk, accumulate one node per cycle
            ST_SUM: begin
                if (r_pend) begin
                    n_sum = r_sum + SUM_W'(fw_cnt);
                end
                if (r_idx != '0) begin
                    fw_re  = 1'b1;
                    n_idx  = walk_next;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = ST_APPLY;
                    end
                end
            end
            // running count update and shrink of the window ends
            ST_APPLY: begin
                n_state = ST_PICK;
                unique case (r_step)
                    STEP_GROW_L: begin
                        n_cnt = r_cnt + RUN_W'(r_sum);
                    end
                    STEP_GROW_R: begin
                        n_cnt = r_cnt + RUN_W'(width) - RUN_W'(r_sum);
                    end
                    STEP_SHRINK_L: begin
                        n_cnt = r_cnt - RUN_W'(r_sum);
                        n_l   = r_l + 1'b1;
                    end
                    STEP_SHRINK_R: begin
                        n_cnt = r_cnt - (RUN_W'(width) - RUN_W'(r_sum));
                        n_r   = r_r - 1'b1;
                    end
                    default: begin
                        n_cnt = r_cnt;
                    end
                endcase
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // config write empties the window like a load
        if (i_cfg_wr_en) begin
            n_elem_count = i_cfg_wr_data;
            clr_win      = 1'b1;
        end

        // empty window: bump the epoch, sweep the tree when it would wrap
        if (clr_win) begin
            n_l   = IDX_W'(1);
            n_r   = '0;
            n_cnt = '0;
            if (r_state != ST_CLEAR) begin
                if (r_epoch == '1) begin
                    n_state    = ST_CLEAR;
                    n_clr_addr = '0;
                end else begin
                    n_epoch = r_epoch + 1'b1;
                end
            end
        end

        // output register
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
        end else begin
            n_out_valid = r_out_valid && !out_acc;
            n_out       = r_out;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_epoch      <= '0;
            r_l          <= IDX_W'(1);
            r_r          <= '0;
            r_cnt        <= '0;
            r_elem_count <= ELEM_COUNT_RST;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_epoch      <= n_epoch;
            r_l          <= n_l;
            r_r          <= n_r;
            r_cnt        <= n_cnt;
            r_elem_count <= n_elem_count;
            r_out_valid  <= n_out_valid;
            r_pend       <= n_pend;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_v        <= n_v;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_sum      <= n_sum;
        r_ql       <= n_ql;
        r_qr       <= n_qr;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // checks
    `RIC_ASSERT_HOLDS(a_window_order, r_l <= r_r + 1'b1, "window left end passed right end")
    `RIC_ASSERT_IMPLIES(a_fw_no_collide, fw_we && fw_re, fw_waddr != fw_raddr, "fenwick read and write hit one entry")
    `RIC_ASSERT_IMPLIES(a_err_zero, o_out_valid && o_out_data.range_error, o_out_data.inversion_count == '0, "error result with nonzero count")

endmodule

[tb/tb_range_inversion_counter_unit.sv]
// self-checking testbench for range_inversion_counter_unit: loads ranks, asks range
// inversion queries and checks every answer against a window and fenwick tree predictor
// depends on ric_pkg and the rtl of range_inversion_counter_unit
`timescale 1ns / 100ps

module tb_range_inversion_counter_unit;
    import ric_pkg::*;

    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 110;
    localparam int SETTLE_TICKS = MAX_ELEMS_DEF + 64;
    localparam int SHOWN_ERRORS = 40;

    // block signals, the driven ones known from time zero
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    t_in_item            in_data = '0;
    logic                in_stall;
    logic                out_valid;
    t_out_item           out_data;
    logic                out_stall = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [FIELD_W-1:0]  cfg_wr_data = '0;

    // transactions waiting to be sent, answers waiting to arrive
    t_in_item  queued_requests[$];
    t_out_item expected_answers[$];

    // predictor state
    logic [FIELD_W-1:0] rank_store [0:MAX_ELEMS_DEF];
    logic [CNT_W-1:0]   tree_counts [0:MAX_ELEMS_DEF];
    logic [FIELD_W-1:0] model_elem_count;
    int unsigned        win_left;
    int unsigned        win_right;
    int unsigned        run_count;

    // stimulus planning state
    bit          written [0:MAX_ELEMS_DEF];
    int unsigned filled_upto;
    int unsigned plan_n;

    // handshake pacing
    int unsigned send_gap = 0;
    bit          send_calm = 1'b0;
    int unsigned hold_left = 0;
    bit          hold_calm = 1'b0;

    // bookkeeping
    int unsigned mismatches = 0;
    int unsigned loads_taken = 0;
    int unsigned queries_taken = 0;
    int unsigned rejected_ranges = 0;
    int unsigned answers_checked = 0;
    int unsigned settings_applied = 0;

    range_inversion_counter_unit #(
        .MAX_ELEMS(MAX_ELEMS_DEF)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_data     (in_data),
        .o_in_stall    (in_stall),
        .o_out_valid   (out_valid),
        .o_out_data    (out_data),
        .i_out_stall   (out_stall),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic int unsigned model_size();
        int unsigned n;
        n = model_elem_count;
        if (n < 1) n = 1;
        if (n > MAX_ELEMS_DEF) n = MAX_ELEMS_DEF;
        return n;
    endfunction

    function automatic void model_clear_window();
        for (int i = 0; i <= MAX_ELEMS_DEF; i++) tree_counts[i] = '0;
        win_left = 1;
        win_right = 0;
        run_count = 0;
    endfunction

    function automatic void model_set_size(input logic [FIELD_W-1:0] value);
        model_elem_count = value;
        model_clear_window();
    endfunction

    // rank at a position, clamped to the tree size
    function automatic int unsigned model_rank(input int unsigned pos, input int unsigned n);
        int unsigned r;
        r = (pos <= MAX_ELEMS_DEF) ? rank_store[pos] : 0;
        if (r < 1) r = 1;
        if (r > n) r = n;
        return r;
    endfunction

    function automatic void model_tree_bump(input int unsigned x, input bit up,
                                            input int unsigned n);
        int unsigned i;
        i = x;
        while (i >= 1 && i <= n) begin
            tree_counts[i] = up ? tree_counts[i] + 1'b1 : tree_counts[i] - 1'b1;
            i += i & (~i + 1);
        end
    endfunction

    function automatic int unsigned model_tree_prefix(input int unsigned x,
                                                      input int unsigned n);
        int unsigned s;
        int unsigned i;
        s = 0;
        i = (x > n) ? n : x;
        while (i != 0) begin
            s += tree_counts[i];
            i -= i & (~i + 1);
        end
        return s;
    endfunction

    // apply one accepted transaction, queue the answer it causes
    function automatic void model_request(input t_in_item req);
        int unsigned n, ql, qr, l, r, v, cnt;
        t_out_item   ans;
        n = model_size();
        if (req.operation == OP_LOAD) begin
            loads_taken++;
            if (req.elem_index >= 1 && req.elem_index <= MAX_ELEMS_DEF)
                rank_store[req.elem_index] = req.elem_rank;
            model_clear_window();
            return;
        end
        queries_taken++;
        ql = req.query_left;
        qr = req.query_right;
        ans = '0;
        if (ql == 0 || ql > qr + 1 || qr > n) begin
            rejected_ranges++;
            ans.range_error = 1'b1;
            expected_answers.push_back(ans);
            return;
        end
        l = win_left;
        r = win_right;
        cnt = run_count;
        // grow left, grow right, then shrink left, shrink right
        while (l > ql) begin
            l--;
            v = model_rank(l, n);
            model_tree_bump(v, 1'b1, n);
            cnt += model_tree_prefix(v - 1, n);
        end
        while (r < qr) begin
            r++;
            v = model_rank(r, n);
            model_tree_bump(v, 1'b1, n);
            cnt += (r - l + 1) - model_tree_prefix(v, n);
        end
        while (l < ql) begin
            v = model_rank(l, n);
            model_tree_bump(v, 1'b0, n);
            cnt -= model_tree_prefix(v - 1, n);
            l++;
        end
        while (r > qr) begin
            v = model_rank(r, n);
            model_tree_bump(v, 1'b0, n);
            cnt -= (r - l) - model_tree_prefix(v, n);
            r--;
        end
        win_left = l;
        win_right = r;
        run_count = cnt & 32'hF_FFFF;
        ans.inversion_count = run_count[OUT_W-1:0];
        expected_answers.push_back(ans);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk) begin
        logic occupied;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            occupied = in_valid;
            if (in_valid && !in_stall) begin
                model_request(in_data);
                occupied = 1'b0;
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 13);
            end
            if (!occupied) begin
                if (send_gap == 0 && queued_requests.size() != 0) begin
                    in_data <= queued_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                    if (send_gap != 0) send_gap--;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                answers_checked++;
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("%0t ns: answer with no transaction pending, count %0d error %0d",
                                 $time, out_data.inversion_count, out_data.range_error);
                end else begin
                    want = expected_answers.pop_front();
                    if (out_data.inversion_count !== want.inversion_count)
                        report_mismatch("inversion_count", want.inversion_count,
                                        out_data.inversion_count);
                    if (out_data.range_error !== want.range_error)
                        report_mismatch("range_error", want.range_error, out_data.range_error);
                end
                if ($urandom_range(0, 39) == 0) hold_calm = !hold_calm;
                hold_left = hold_calm ? 0 : $urandom_range(0, 13);
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_load(input int unsigned idx, input int unsigned rank);
        t_in_item it;
        it.operation = OP_LOAD;
        it.elem_index = idx[FIELD_W-1:0];
        it.elem_rank = rank[FIELD_W-1:0];
        it.query_left = $urandom;
        it.query_right = $urandom;
        queued_requests.push_back(it);
        if (idx >= 1 && idx <= MAX_ELEMS_DEF) written[idx] = 1'b1;
        while (filled_upto < MAX_ELEMS_DEF && written[filled_upto + 1]) filled_upto++;
    endtask

    task automatic queue_query(input int unsigned ql, input int unsigned qr);
        t_in_item it;
        it.operation = OP_QUERY;
        it.elem_index = $urandom;
        it.elem_rank = $urandom;
        it.query_left = ql[FIELD_W-1:0];
        it.query_right = qr[FIELD_W-1:0];
        queued_requests.push_back(it);
    endtask

    // mostly small-rank loads and in-bounds queries, some broken ranges
    task automatic queue_random_item();
        int unsigned pick, top, ql, qr, idx, rank;
        pick = $urandom_range(0, 99);
        top = (filled_upto < plan_n) ? filled_upto : plan_n;
        if (pick < 14) begin
            case ($urandom_range(0, 9))
                0: idx = 0;
                1: idx = $urandom_range(MAX_ELEMS_DEF + 1, 2047);
                2: idx = $urandom_range(1, MAX_ELEMS_DEF);
                default: idx = $urandom_range(1, (filled_upto < 40) ? filled_upto + 1
                                                                     : filled_upto);
            endcase
            rank = ($urandom_range(0, 4) == 0) ? ($urandom & 32'h7FF) : $urandom_range(1, 24);
            queue_load(idx, rank);
        end else if (pick < 88) begin
            qr = $urandom_range(0, top);
            ql = $urandom_range(1, qr + 1);
            queue_query(ql, qr);
        end else begin
            case ($urandom_range(0, 2))
                0: queue_query(0, $urandom & 32'h7FF);
                1: begin
                    qr = $urandom_range(0, 2045);
                    queue_query($urandom_range(qr + 2, 2047), qr);
                end
                default: queue_query($urandom & 32'h7FF, $urandom_range(plan_n + 1, 2047));
            endcase
        end
    endtask

    // hold off until every sent transaction has been answered
    task automatic wait_for_quiet();
        while (queued_requests.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // register write only once the block is idle, tree sweep included
    task automatic apply_elem_count(input logic [FIELD_W-1:0] value);
        wait_for_quiet();
        repeat (SETTLE_TICKS) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_set_size(value);
        plan_n = model_size();
        settings_applied++;
    endtask

    function automatic logic [FIELD_W-1:0] phase_setting(input int p);
        case (p)
            0: return 11'd1;
            1: return 11'd0;
            2: return 11'd2047;
            3: return 11'd1024;
            4: return 11'd2;
            default: return (p % 2) ? 11'($urandom_range(1, 48)) : 11'($urandom & 32'h7FF);
        endcase
    endfunction

    // main sequence
    initial begin
        int unsigned target;
        for (int i = 0; i <= MAX_ELEMS_DEF; i++) begin
            rank_store[i] = '0;
            written[i] = 1'b0;
        end
        filled_upto = 0;
        model_set_size(ELEM_COUNT_RST);
        plan_n = model_size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: rank extremes, equal ranks, ignored load indexes, edge ranges
        queue_load(1, 5);
        queue_load(2, 3);
        queue_load(3, 3);
        queue_load(4, 0);
        queue_load(0, 7);
        queue_load(5, 2047);
        queue_load(6, 1024);
        queue_load(7, 1);
        queue_load(8, 2);
        queue_query(1, 8);
        queue_query(3, 6);
        queue_query(1, 0);
        queue_query(9, 8);
        queue_load(2047, 3);
        queue_query(5, 8);
        queue_query(2, 3);
        queue_query(0, 4);
        queue_query(6, 4);
        queue_query(1, 1025);
        queue_query(2047, 2047);
        queue_load(1024, 9);
        queue_query(1, 8);
        queue_query(8, 8);

        // random phases, one register setting each
        for (int p = 0; p < PHASES; p++) begin
            apply_elem_count(phase_setting(p));
            target = $urandom_range(6, 32);
            while (filled_upto < target) queue_load(filled_upto + 1, $urandom_range(1, 24));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) wait_for_quiet();
                queue_random_item();
            end
        end

        wait_for_quiet();
        repeat (SETTLE_TICKS) @(posedge clk);
        $display("run covered %0d loads and %0d range queries (%0d rejected) over %0d sizes",
                 loads_taken, queries_taken, rejected_ranges, settings_applied + 1);
        $display("%0d answers checked, %0d mismatches", answers_checked, mismatches);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("tb_range_inversion_counter_unit OK");
        end else begin
            $display("tb_range_inversion_counter_unit NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #600_000_000;
        $display("tb_range_inversion_counter_unit NOT OK");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ric_pkg.sv
rtl/ric_ram.sv
rtl/range_inversion_counter_unit.sv
tb/tb_range_inversion_counter_unit.sv
